FILE: rtl/core/hci_pkg.sv
// ----------------------------------------------------------------------------
// hci_pkg: shared types and constants for the hash chain insert block
// Hash multiplier, widths, queue depth, register map and the queue entry.
// ----------------------------------------------------------------------------
package hci_pkg;

  // Multiplicative hash
  localparam logic [31:0] HASH_MULT  = 32'd2654435761;
  localparam int          HASH_SHIFT = 16;

  // Field widths
  localparam int POS_W     = 16;
  localparam int WORD_W    = 32;
  localparam int HASH_W    = 16;   // widest hash, also the result field width
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 2;

  // Default parameter values
  localparam int HASH_BITS_DEF   = 16;
  localparam int WINDOW_BITS_DEF = 15;

  // Front-to-back queue depth
  localparam int QUEUE_DEPTH = 4;

  // Register map
  localparam logic [ADDR_W-1:0] REG_WINDOW_MASK = 2'd0;
  localparam logic [POS_W-1:0]  WINDOW_MASK_RST = 16'd32767;

  // One insert request as it travels from the front to the back
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
    logic              last;
  } req_t;

endpackage

FILE: rtl/core/hci_front.sv
// ----------------------------------------------------------------------------
// hci_front: request capture and hash stage
// Registers an accepted request, hashes its word and pushes it to the queue.
// ----------------------------------------------------------------------------
module hci_front
  import hci_pkg::*;
#(
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [POS_W-1:0]  position,
  input  logic [WORD_W-1:0] word_at_position,
  input  logic              last_in_run,
  input  logic              q_full,
  output logic              stall,
  output logic              q_push,
  output req_t              q_data
);

  logic              valid_r, valid_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] word_r;
  logic              last_r;
  logic [WORD_W-1:0] prod;

  // Stage holds a request until the queue takes it
  assign q_push = valid_r & ~q_full;
  assign stall  = valid_r & q_full;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r  <= position;
      word_r <= word_at_position;
      last_r <= last_in_run;
    end
  end

  // Product modulo 2^32, bucket from the upper half
  assign prod = word_r * HASH_MULT;

  always_comb begin
    q_data      = '0;
    q_data.hash = HASH_W'(prod[HASH_SHIFT +: HASH_BITS]);
    q_data.pos  = pos_r;
    q_data.last = last_r;
  end

endmodule

FILE: rtl/core/hci_queue.sv
// ----------------------------------------------------------------------------
// hci_queue: short request queue between front and back
// Small register FIFO; push and pop in the same cycle are allowed.
// ----------------------------------------------------------------------------
module hci_queue
  import hci_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_data,
  input  logic pop,
  output req_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/hci_back.sv
// ----------------------------------------------------------------------------
// hci_back: head/prev table update and result stage
// Clears the head table after reset, then per request reads the head entry,
// links it into the prev table when it changes and emits the result.
// ----------------------------------------------------------------------------
module hci_back
  import hci_pkg::*;
#(
  parameter int HASH_BITS   = HASH_BITS_DEF,
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [POS_W-1:0]  window_mask,
  input  logic              q_empty,
  input  req_t              q_data,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_strobe,
  output logic [HASH_W-1:0] out_hash_value,
  output logic [POS_W-1:0]  out_old_head,
  output logic              out_chain_updated,
  output logic              out_run_done
);

  localparam int HEAD_DEPTH = 1 << HASH_BITS;
  localparam int PREV_DEPTH = 1 << WINDOW_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [HASH_BITS-1:0]   clr_addr_r;
  req_t                   cur_r;
  logic [POS_W-1:0]       head_rd_r;
  logic [POS_W-1:0]       head_mem [HEAD_DEPTH];
  logic [POS_W-1:0]       prev_mem [PREV_DEPTH];
  logic                   changed;
  logic                   head_we;
  logic [HASH_BITS-1:0]   head_waddr;
  logic [POS_W-1:0]       head_wdata;
  logic [WINDOW_BITS-1:0] prev_addr;
  logic [POS_W-1:0]       masked_pos;
  logic                   strobe_r;

  assign clearing = (state_r == ST_CLEAR);
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign changed  = (head_rd_r != cur_r.pos);

  // Sequencer: clear sweep, then read / check per request
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == {HASH_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == ST_CHECK);
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Capture the popped request
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  // Head table write select: clear sweep or update
  always_comb begin
    head_we    = 1'b0;
    head_waddr = cur_r.hash[HASH_BITS-1:0];
    head_wdata = cur_r.pos;
    if (state_r == ST_CLEAR) begin
      head_we    = 1'b1;
      head_waddr = clr_addr_r;
      head_wdata = '0;
    end else if (state_r == ST_CHECK && changed) begin
      head_we = 1'b1;
    end
  end

  // Head table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_r <= head_mem[q_data.hash[HASH_BITS-1:0]];
  end

  // Prev table: link old head at the masked position
  assign masked_pos = cur_r.pos & window_mask;
  assign prev_addr  = masked_pos[WINDOW_BITS-1:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK && changed) begin
      prev_mem[prev_addr] <= head_rd_r;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      out_hash_value    <= cur_r.hash;
      out_old_head      <= head_rd_r;
      out_chain_updated <= changed;
      out_run_done      <= cur_r.last;
    end
  end

  assign out_strobe = strobe_r;

`ifndef NO_ASSERTIONS
  // A result follows a check cycle and nothing else
  a_strobe_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(state_r == ST_CHECK))
    else $error("result strobe without a check cycle");

  // No request leaves the queue while the head table is being cleared
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !q_pop)
    else $error("queue popped during head clear");

  // Every pop is followed by a check cycle
  a_pop_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_CHECK))
    else $error("pop not followed by check");

  // Update flag matches a changed head entry
  a_updated_flag: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (out_chain_updated == (out_old_head != $past(cur_r.pos))))
    else $error("chain_updated inconsistent with old head");
`endif

endmodule

FILE: rtl/core/hash_chain_insert.sv
// ----------------------------------------------------------------------------
// hash_chain_insert: deflate hash chain insertion with multiplicative hash
// Hashes each inserted word, swaps the head table entry and links the old
// head into the prev table.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ------------------------------
//   request   start, busy, in_*              taken when start & !busy
//   result    out_strobe, out_*              one-cycle strobe, no backpressure
//   config    psel/penable/pwrite/paddr/...  APB write on access phase
//
// A request is registered and hashed in the front stage and queued; the table stage
// then reads the head entry, then compares and writes. The table stage takes no new
// request until it is through with the last one, and so sets the steady rate.
// After reset the head table is swept to zero, one entry per cycle, over
// 2^HASH_BITS entries (65536 by default) with busy high. A four-entry queue
// lets requests pile up; busy rises when it and the hash stage are full.
// ----------------------------------------------------------------------------
module hash_chain_insert
  import hci_pkg::*;
#(
  parameter int HASH_BITS   = HASH_BITS_DEF,
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [POS_W-1:0]  in_position,
  input  logic [WORD_W-1:0] in_word_at_position,
  input  logic              in_last_in_run,
  // result channel
  output logic              out_strobe,
  output logic [HASH_W-1:0] out_hash_value,
  output logic [POS_W-1:0]  out_old_head,
  output logic              out_chain_updated,
  output logic              out_run_done,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic             accept;
  logic             front_stall;
  logic             clearing;
  logic             q_push, q_pop, q_full, q_empty;
  req_t             push_data, pop_data;
  logic [POS_W-1:0] window_mask_r;

  assign busy   = clearing | front_stall;
  assign accept = start & ~busy;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_mask_r <= WINDOW_MASK_RST;
    end else if (psel && penable && pwrite && pready && paddr == REG_WINDOW_MASK) begin
      window_mask_r <= pwdata[POS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_WINDOW_MASK) begin
      prdata = DATA_W'(window_mask_r);
    end
  end

  hci_front #(
    .HASH_BITS (HASH_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .position         (in_position),
    .word_at_position (in_word_at_position),
    .last_in_run      (in_last_in_run),
    .q_full           (q_full),
    .stall            (front_stall),
    .q_push           (q_push),
    .q_data           (push_data)
  );

  hci_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  hci_back #(
    .HASH_BITS   (HASH_BITS),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .window_mask       (window_mask_r),
    .q_empty           (q_empty),
    .q_data            (pop_data),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_strobe        (out_strobe),
    .out_hash_value    (out_hash_value),
    .out_old_head      (out_old_head),
    .out_chain_updated (out_chain_updated),
    .out_run_done      (out_run_done)
  );

endmodule
